@@ rtl/nma_pkg.sv @@
// Package for the normalized mixer adjoint: sizes, codes, lane control
// struct and count clamping. Used by every module of the block.
package nma_pkg;

   localparam int MaxChannels  = 4;
   localparam int MaxSources   = 8;
   localparam int ColW         = $clog2(MaxSources);
   localparam int RowW         = 2;
   localparam int SumW         = 33;  // sum of up to four squares
   localparam int SearchW      = 66;  // trial terms of the root search
   localparam int MagW         = 16;  // scaled magnitude, 0..32768

   typedef enum logic [1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_NORM   = 2'd1,
      FUNC_SAMPLE = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [0:0] {
      CSR_CHANNELS = 1'b0,
      CSR_SOURCES  = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SMP,
      ST_DRAIN,
      ST_N_RD,
      ST_N_MUL,
      ST_N_SUM,
      ST_N_CHK,
      ST_N_SRCH,
      ST_N_WR
   } state_type;

   // Control shared by all lanes
   typedef struct packed {
      logic               rd_en;
      logic [ColW-1:0]    addr;
      logic               ld_en;
      logic signed [15:0] ld_data;
      logic               sq;
      logic               init;
      logic               step;
      logic [3:0]         bitpos;
      logic               wr_back;
      logic [SumW-1:0]    sum;
   } lane_ctl_type;

   function automatic logic [2:0] used_channels(input logic [2:0] c);
      logic [2:0] r;
      r = c;
      if (c == 3'd0) r = 3'd1;
      if (c > 3'(MaxChannels)) r = 3'(MaxChannels);
      return r;
   endfunction

   function automatic logic [3:0] used_sources(input logic [3:0] s);
      logic [3:0] r;
      r = s;
      if (s == 4'd0) r = 4'd1;
      if (s > 4'(MaxSources)) r = 4'(MaxSources);
      return r;
   endfunction

endpackage

@@ rtl/normalized_mixer_adjoint.sv @@
// Top level of the normalized mixer adjoint: sequencer, configuration
// registers, lanes and merge. Depends on nma_pkg, nma_lane, nma_merge.
//
//   channel  | ports                              | direction
//   request  | start, busy, req_*                 | in (busy out)
//   result   | rsp_valid, rsp_*                   | out, one cycle each
//   config   | csr_we, csr_index, csr_wdata       | in
//
// A load transaction writes its coefficient at acceptance and leaves busy
// low. A sample transaction reads one column per cycle from the lane
// memories; results stream out one per cycle through the read, product
// and merge registers. Normalize works column by column (read, multiply,
// sum, check, 16-step root search, write back; a zero sum skips the last two).
// Reset is synchronous; the matrix has no reset. Results cannot be stalled.
module normalized_mixer_adjoint (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_func,
   input  logic [1:0]                  req_row_channel,
   input  logic [2:0]                  req_column_source,
   input  logic signed [15:0]          req_coefficient,
   input  logic signed [15:0]          req_sample0,
   input  logic signed [15:0]          req_sample1,
   input  logic signed [15:0]          req_sample2,
   input  logic signed [15:0]          req_sample3,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_source_number,
   output logic signed [17:0]          rsp_source_value,
   output logic                        rsp_last,
   input  logic                        csr_we,
   input  logic [0:0]                  csr_index,
   input  logic [3:0]                  csr_wdata
);
   import nma_pkg::*;

   state_type          state_ff, state_in;
   logic [2:0]         chan_ff;
   logic [3:0]         src_ff;
   logic [2:0]         nc;
   logic [3:0]         ns;
   logic [ColW-1:0]    col_ff, col_in;
   logic [3:0]         bit_ff, bit_in;
   logic [SumW-1:0]    s_ff, s_in;
   logic signed [15:0] smp_ff [MaxChannels];
   logic               accept;
   lane_ctl_type       ctl;
   logic signed [31:0] lane_prod [MaxChannels];
   logic [MaxChannels-1:0] lane_use;
   logic signed [33:0] sum;
   logic signed [18:0] shifted;
   logic               v1_ff, v2_ff, v3_ff, v1_in;
   logic [ColW-1:0]    n1_ff, n2_ff, n3_ff;
   logic               l1_ff, l2_ff, l3_ff, l1_in;

   assign nc     = used_channels(chan_ff);
   assign ns     = used_sources(src_ff);
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= 3'd2;
         src_ff  <= 4'd2;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CHANNELS: chan_ff <= csr_wdata[2:0];
            CSR_SOURCES:  src_ff  <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // Hold the samples of an accepted transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         smp_ff[0] <= req_sample0;
         smp_ff[1] <= req_sample1;
         smp_ff[2] <= req_sample2;
         smp_ff[3] <= req_sample3;
      end
   end

   always_comb begin
      for (int k = 0; k < MaxChannels; k++) lane_use[k] = (3'(k) < nc);
   end

   // Sequencer: next state and lane control
   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      bit_in      = bit_ff;
      s_in        = s_ff;
      v1_in       = 1'b0;
      l1_in       = 1'b0;
      ctl         = '0;
      ctl.sq      = 1'b1;
      ctl.addr    = col_ff;
      ctl.bitpos  = bit_ff;
      ctl.sum     = s_ff;
      ctl.ld_data = req_coefficient;
      unique case (state_ff)
         ST_IDLE: begin
            col_in = '0;
            if (accept) begin
               unique case (func_type'(req_func))
                  FUNC_LOAD: begin
                     ctl.ld_en = 1'b1;
                     ctl.addr  = req_column_source;
                  end
                  FUNC_NORM:   state_in = ST_N_RD;
                  FUNC_SAMPLE: state_in = ST_SMP;
                  default:     ;
               endcase
            end
         end
         ST_SMP: begin
            ctl.sq    = 1'b0;
            ctl.rd_en = 1'b1;
            v1_in     = 1'b1;
            l1_in     = (4'(col_ff) + 4'd1 == ns);
            col_in    = col_ff + 1'b1;
            if (l1_in) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            ctl.sq = 1'b0;
            if (!v1_ff && !v2_ff) state_in = ST_IDLE;
         end
         ST_N_RD: begin
            ctl.rd_en = 1'b1;
            state_in  = ST_N_MUL;
         end
         ST_N_MUL: state_in = ST_N_SUM;
         ST_N_SUM: state_in = ST_N_CHK;
         ST_N_CHK: begin
            s_in = sum[SumW-1:0];
            if (sum == '0) begin
               col_in   = col_ff + 1'b1;
               state_in = (4'(col_ff) + 4'd1 == ns) ? ST_IDLE : ST_N_RD;
            end else begin
               ctl.init = 1'b1;
               bit_in   = 4'd15;
               state_in = ST_N_SRCH;
            end
         end
         ST_N_SRCH: begin
            ctl.step = 1'b1;
            bit_in   = bit_ff - 4'd1;
            if (bit_ff == 4'd0) state_in = ST_N_WR;
         end
         ST_N_WR: begin
            ctl.wr_back = 1'b1;
            col_in      = col_ff + 1'b1;
            state_in    = (4'(col_ff) + 4'd1 == ns) ? ST_IDLE : ST_N_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= v1_in;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
      end
   end

   // Advance column, bit, sum and tag registers
   always_ff @(posedge clock) begin
      col_ff <= col_in;
      bit_ff <= bit_in;
      s_ff   <= s_in;
      n1_ff  <= col_ff;
      l1_ff  <= l1_in;
      n2_ff  <= n1_ff;
      l2_ff  <= l1_ff;
      n3_ff  <= n2_ff;
      l3_ff  <= l2_ff;
   end

   for (genvar k = 0; k < MaxChannels; k++) begin : g_lane
      nma_lane u_lane (
         .clock    (clock),
         .ctl      (ctl),
         .ld_sel   (req_row_channel == RowW'(k)),
         .use_lane (lane_use[k]),
         .sample   (smp_ff[k]),
         .product  (lane_prod[k])
      );
   end

   nma_merge u_merge (
      .clock     (clock),
      .lane_prod (lane_prod),
      .lane_use  (lane_use),
      .sum       (sum)
   );

   // Floor shift and saturate the merged sum
   assign shifted = 19'(sum >>> 15);

   always_comb begin
      if (shifted > 19'sd131071)       rsp_source_value = 18'sd131071;
      else if (shifted < -19'sd131072) rsp_source_value = -18'sd131072;
      else                             rsp_source_value = shifted[17:0];
   end

   assign rsp_valid         = v3_ff;
   assign rsp_source_number = n3_ff;
   assign rsp_last          = l3_ff;

`ifndef SYNTHESIS
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result directly after last");
   a_next_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid &&
         rsp_source_number == $past(rsp_source_number) + 3'd1)
      else $error("source sequence broken");
   a_load_one: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_func == FUNC_LOAD |=> !busy)
      else $error("load left block busy");
`endif
endmodule

@@ rtl/nma_lane.sv @@
// One channel lane: its row of the matrix, a multiplier and a bit-serial
// root search for normalizing. Depends on nma_pkg.
module nma_lane (
   input  logic                      clock,
   input  nma_pkg::lane_ctl_type     ctl,
   input  logic                      ld_sel,
   input  logic                      use_lane,
   input  logic signed [15:0]        sample,
   output logic signed [31:0]        product
);
   import nma_pkg::*;

   logic signed [15:0] row_mem [MaxSources];
   logic signed [15:0] rd_ff;
   logic signed [31:0] prod_ff, prod_in;
   logic [SearchW-1:0] p_ff, p_in, q_ff, q_in, tgt_ff, tgt_in, trial, s_ext;
   logic [MagW-1:0]    m_ff, m_in;
   logic signed [15:0] new_val;
   logic               we;
   logic signed [15:0] wdata;

   // Trial (m + 2^b)^2 * S built from running m^2*S and m*S
   assign s_ext = SearchW'(ctl.sum);
   assign trial = p_ff + (q_ff << (5'(ctl.bitpos) + 5'd1))
                       + (s_ext << {ctl.bitpos, 1'b0});

   always_comb begin
      p_in   = p_ff;
      q_in   = q_ff;
      m_in   = m_ff;
      tgt_in = tgt_ff;
      if (ctl.init) begin
         p_in   = '0;
         q_in   = '0;
         m_in   = '0;
         tgt_in = SearchW'(prod_ff[30:0]) << 30;
      end else if (ctl.step && trial <= tgt_ff) begin
         p_in = trial;
         q_in = q_ff + (s_ext << ctl.bitpos);
         m_in = m_ff | (MagW'(1) << ctl.bitpos);
      end
   end

   // Saturate +1.0 and restore the sign
   always_comb begin
      if (m_ff[MagW-1])
         new_val = rd_ff[15] ? 16'sh8000 : 16'sh7fff;
      else if (rd_ff[15])
         new_val = -$signed({1'b0, m_ff[14:0]});
      else
         new_val = $signed({1'b0, m_ff[14:0]});
   end

   assign prod_in = rd_ff * (ctl.sq ? rd_ff : sample);
   assign we      = (ctl.ld_en && ld_sel) || (ctl.wr_back && use_lane);
   assign wdata   = ctl.ld_en ? ctl.ld_data : new_val;

   // Row memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (we) row_mem[ctl.addr] <= wdata;
      if (ctl.rd_en) rd_ff <= row_mem[ctl.addr];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      m_ff    <= m_in;
      tgt_ff  <= tgt_in;
   end

   assign product = prod_ff;
endmodule

@@ rtl/nma_merge.sv @@
// Merge stage: adds the lane products of channels in use and registers
// the sum. Depends on nma_pkg.
module nma_merge (
   input  logic                       clock,
   input  logic signed [31:0]         lane_prod [nma_pkg::MaxChannels],
   input  logic [nma_pkg::MaxChannels-1:0] lane_use,
   output logic signed [33:0]         sum
);
   import nma_pkg::*;

   logic signed [33:0] sum_ff, sum_in;

   // Add the lanes in use
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < MaxChannels; k++)
         if (lane_use[k]) sum_in = sum_in + 34'(lane_prod[k]);
   end

   always_ff @(posedge clock) sum_ff <= sum_in;

   assign sum = sum_ff;
endmodule
